// File: design/kabf_pkg.sv
// Package with shared types and constants of the angle/bias filter.
`timescale 1ns / 1ps
package kabf_pkg;

    localparam int WORD_BITS_DEF = 32;
    localparam int FRAC_BITS_DEF = 24;
    localparam int CFG_BITS      = 24;
    localparam int CFG_IDX_BITS  = 2;

    localparam logic [CFG_IDX_BITS-1:0] REG_ANGLE_NOISE   = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_BIAS_NOISE    = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_MEASURE_NOISE = 2'd2;

    localparam logic [CFG_BITS-1:0] ANGLE_NOISE_RST   = 24'd16777;
    localparam logic [CFG_BITS-1:0] BIAS_NOISE_RST    = 24'd50332;
    localparam logic [CFG_BITS-1:0] MEASURE_NOISE_RST = 24'd503316;

    localparam logic CMD_STEP = 1'b0;
    localparam logic CMD_SEED = 1'b1;

    typedef struct packed {
        logic               command;
        logic signed [31:0] measured_angle;
        logic signed [31:0] gyro_rate;
        logic [23:0]        time_step;
    } kabf_in_t;

    typedef struct packed {
        logic signed [31:0] angle_estimate;
        logic signed [31:0] bias_estimate;
    } kabf_out_t;

    // Datapath operations issued by the controller.
    typedef enum logic [2:0] {
        OP_NONE,
        OP_MUL,
        OP_ADD,
        OP_SUB,
        OP_DIV,
        OP_LOAD
    } kabf_op_t;

    // Register file addresses of the datapath.
    typedef enum logic [3:0] {
        R_ANG, R_BIAS, R_PAA, R_PAB, R_PBA, R_PBB,
        R_MEAS, R_GYRO, R_DT, R_QA, R_QB, R_RM,
        R_T0, R_T1, R_T2, R_T3
    } kabf_reg_t;

    typedef struct packed {
        kabf_op_t  op;
        kabf_reg_t src_a;
        kabf_reg_t src_b;
        kabf_reg_t dst;
    } kabf_cmd_t;

    typedef struct packed {
        logic busy;
    } kabf_stat_t;

endpackage

// File: design/kabf_datapath.sv
// Datapath of the filter: register file, shared multiplier and serial divider.
`timescale 1ns / 1ps
module kabf_datapath
    import kabf_pkg::*;
#(
    parameter int WORD_BITS = WORD_BITS_DEF,
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cmd_valid,
    input  kabf_cmd_t            cmd,
    output kabf_stat_t           stat,
    input  logic                 load_in,
    input  kabf_in_t             in_item,
    input  logic [CFG_BITS-1:0]  qa_cfg,
    input  logic [CFG_BITS-1:0]  qb_cfg,
    input  logic [CFG_BITS-1:0]  rm_cfg,
    output kabf_out_t            result
);

    localparam int PW    = 2 * WORD_BITS;
    localparam int NW    = WORD_BITS + FRAC_BITS;
    localparam int CNT_W = $clog2(NW + 1);
    localparam logic signed [WORD_BITS-1:0] WMAX = {1'b0, {(WORD_BITS-1){1'b1}}};
    localparam logic signed [WORD_BITS-1:0] WMIN = {1'b1, {(WORD_BITS-1){1'b0}}};

    typedef logic signed [WORD_BITS-1:0] word_t;

    word_t rf_reg [16];

    function automatic word_t sat_wide(input logic signed [PW:0] v);
        word_t r;
        if (v > PW'(WMAX))       r = WMAX;
        else if (v < $signed({{(PW-WORD_BITS+1){1'b1}}, WMIN})) r = WMIN;
        else                     r = v[WORD_BITS-1:0];
        return r;
    endfunction

    function automatic word_t from_s32(input logic signed [31:0] v);
        return sat_wide($signed({{(PW+1-32){v[31]}}, v}));
    endfunction

    function automatic word_t from_q24(input logic [CFG_BITS-1:0] u);
        logic [PW:0] e;
        if (FRAC_BITS >= CFG_BITS)
            e = (PW+1)'(u) << (FRAC_BITS - CFG_BITS);
        else
            e = ((PW+1)'(u) + ((PW+1)'(1) << (CFG_BITS - 1 - FRAC_BITS)))
                >> (CFG_BITS - FRAC_BITS);
        return sat_wide($signed(e));
    endfunction

    function automatic logic [31:0] to_s32(input word_t v);
        logic signed [PW:0] e;
        e = {{(PW+1-WORD_BITS){v[WORD_BITS-1]}}, v};
        if (e > (PW+1)'(32'sh7FFFFFFF)) return 32'h7FFFFFFF;
        if (e < -(PW+1)'(64'sd2147483648)) return 32'h80000000;
        return e[31:0];
    endfunction

    // Operand read
    word_t a, b;
    assign a = rf_reg[cmd.src_a];
    assign b = rf_reg[cmd.src_b];

    // Multiplier: magnitude product registered, rounding and saturation next cycle.
    logic [WORD_BITS-1:0] ma, mb;
    assign ma = a[WORD_BITS-1] ? WORD_BITS'(-a) : a;
    assign mb = b[WORD_BITS-1] ? WORD_BITS'(-b) : b;

    logic [PW-1:0] prod_reg;
    logic          pneg_reg;
    kabf_reg_t     mdst_reg;
    logic          mpend_reg;

    function automatic word_t sat_mag(input logic [PW:0] m, input logic neg);
        logic [PW:0] lim;
        lim = neg ? ((PW+1)'(1) << (WORD_BITS-1)) : (PW+1)'(WMAX);
        if (m > lim) m = lim;
        return neg ? WORD_BITS'(-m) : m[WORD_BITS-1:0];
    endfunction

    logic [PW:0] rnd;
    assign rnd = ((PW+1)'(prod_reg) + ((PW+1)'(1) << (FRAC_BITS-1))) >> FRAC_BITS;

    // Divider: restoring, one quotient bit per cycle.
    logic [NW-1:0]       dn_reg, dq_reg;
    logic [WORD_BITS:0]  dr_reg;
    logic [WORD_BITS-1:0] dd_reg;
    logic [CNT_W-1:0]    dcnt_reg;
    logic                dneg_reg, dzero_reg, dbusy_reg, dfin_reg;
    kabf_reg_t           ddst_reg;

    logic [WORD_BITS:0]  dr_sh;
    logic                dge;
    assign dr_sh = {dr_reg[WORD_BITS-1:0], dn_reg[NW-1]};
    assign dge   = dr_sh >= (WORD_BITS+1)'(dd_reg);

    logic [WORD_BITS:0] rem_left;
    assign rem_left = (WORD_BITS+1)'(dd_reg) - dr_reg;

    assign stat.busy = mpend_reg | dbusy_reg | dfin_reg;

    logic signed [PW:0] ea, eb;
    assign ea = {{(PW+1-WORD_BITS){a[WORD_BITS-1]}}, a};
    assign eb = {{(PW+1-WORD_BITS){b[WORD_BITS-1]}}, b};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 16; i++) rf_reg[i] <= '0;
            mpend_reg <= 1'b0;
            dbusy_reg <= 1'b0;
            dfin_reg  <= 1'b0;
        end
        else
        begin
            mpend_reg <= 1'b0;
            dfin_reg  <= 1'b0;
            if (load_in)
            begin
                rf_reg[R_MEAS] <= from_s32(in_item.measured_angle);
                rf_reg[R_GYRO] <= from_s32(in_item.gyro_rate);
                rf_reg[R_DT]   <= from_q24(in_item.time_step);
                rf_reg[R_QA]   <= from_q24(qa_cfg);
                rf_reg[R_QB]   <= from_q24(qb_cfg);
                rf_reg[R_RM]   <= from_q24(rm_cfg);
            end
            if (mpend_reg)
                rf_reg[mdst_reg] <= sat_mag(rnd, pneg_reg);
            if (cmd_valid)
            begin
                case (cmd.op)
                    OP_MUL:
                    begin
                        prod_reg  <= ma * mb;
                        pneg_reg  <= a[WORD_BITS-1] ^ b[WORD_BITS-1];
                        mdst_reg  <= cmd.dst;
                        mpend_reg <= 1'b1;
                    end
                    OP_ADD:  rf_reg[cmd.dst] <= sat_wide(ea + eb);
                    OP_SUB:  rf_reg[cmd.dst] <= sat_wide(ea - eb);
                    OP_LOAD: rf_reg[cmd.dst] <= a;
                    OP_DIV:
                    begin
                        dn_reg    <= {ma, {FRAC_BITS{1'b0}}};
                        dd_reg    <= mb;
                        dr_reg    <= '0;
                        dq_reg    <= '0;
                        dcnt_reg  <= CNT_W'(NW);
                        dneg_reg  <= a[WORD_BITS-1] ^ b[WORD_BITS-1];
                        dzero_reg <= (b == '0);
                        ddst_reg  <= cmd.dst;
                        dbusy_reg <= 1'b1;
                    end
                    default: ;
                endcase
            end
            if (dbusy_reg)
            begin
                dn_reg   <= dn_reg << 1;
                dr_reg   <= dge ? dr_sh - (WORD_BITS+1)'(dd_reg) : dr_sh;
                dq_reg   <= {dq_reg[NW-2:0], dge};
                dcnt_reg <= dcnt_reg - 1'b1;
                if (dcnt_reg == CNT_W'(1))
                begin
                    dbusy_reg <= 1'b0;
                    dfin_reg  <= 1'b1;
                end
            end
            if (dfin_reg)
            begin
                if (dzero_reg)
                    rf_reg[ddst_reg] <= '0;
                else
                    rf_reg[ddst_reg] <= sat_mag((PW+1)'(dq_reg)
                        + (PW+1)'(dr_reg >= rem_left), dneg_reg);
            end
        end
    end

    assign result.angle_estimate = to_s32(rf_reg[R_ANG]);
    assign result.bias_estimate  = to_s32(rf_reg[R_BIAS]);

endmodule

// File: design/kabf_ctrl.sv
// Sequencer that walks the predict and update program over the datapath.
`timescale 1ns / 1ps
module kabf_ctrl
    import kabf_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic       in_cmd,
    output logic       in_ready,
    output logic       load_in,
    output logic       cmd_valid,
    output kabf_cmd_t  cmd,
    input  kabf_stat_t stat,
    input  logic       out_hold,
    output logic       done
);

    localparam int PROG_LEN = 28;
    localparam int PC_W = $clog2(PROG_LEN + 1);

    typedef enum logic [1:0] { S_IDLE, S_RUN, S_WAIT, S_SEED } state_t;

    state_t          state_reg;
    logic [PC_W-1:0] pc_reg;

    function automatic kabf_cmd_t prog(input logic [PC_W-1:0] pc);
        kabf_cmd_t c;
        case (pc)
            0:  c = '{OP_SUB, R_GYRO, R_BIAS, R_T0};
            1:  c = '{OP_MUL, R_DT,   R_T0,   R_T0};
            2:  c = '{OP_ADD, R_ANG,  R_T0,   R_ANG};
            3:  c = '{OP_MUL, R_DT,   R_PBB,  R_T1};
            4:  c = '{OP_SUB, R_T1,   R_PAB,  R_T0};
            5:  c = '{OP_SUB, R_T0,   R_PBA,  R_T0};
            6:  c = '{OP_ADD, R_T0,   R_QA,   R_T0};
            7:  c = '{OP_MUL, R_DT,   R_T0,   R_T0};
            8:  c = '{OP_ADD, R_PAA,  R_T0,   R_PAA};
            9:  c = '{OP_SUB, R_PAB,  R_T1,   R_PAB};
            10: c = '{OP_SUB, R_PBA,  R_T1,   R_PBA};
            11: c = '{OP_MUL, R_QB,   R_DT,   R_T0};
            12: c = '{OP_ADD, R_PBB,  R_T0,   R_PBB};
            13: c = '{OP_SUB, R_MEAS, R_ANG,  R_T2};
            14: c = '{OP_ADD, R_PAA,  R_RM,   R_T3};
            15: c = '{OP_DIV, R_PAA,  R_T3,   R_T0};
            16: c = '{OP_DIV, R_PBA,  R_T3,   R_T1};
            17: c = '{OP_MUL, R_T0,   R_T2,   R_T3};
            18: c = '{OP_ADD, R_ANG,  R_T3,   R_ANG};
            19: c = '{OP_MUL, R_T1,   R_T2,   R_T3};
            20: c = '{OP_ADD, R_BIAS, R_T3,   R_BIAS};
            21: c = '{OP_MUL, R_T1,   R_PAB,  R_T3};
            22: c = '{OP_SUB, R_PBB,  R_T3,   R_PBB};
            23: c = '{OP_MUL, R_T0,   R_PAB,  R_T3};
            24: c = '{OP_SUB, R_PAB,  R_T3,   R_PAB};
            25: c = '{OP_MUL, R_T1,   R_PAA,  R_T3};
            26: c = '{OP_SUB, R_PBA,  R_T3,   R_PBA};
            27: c = '{OP_MUL, R_T0,   R_PAA,  R_T3};
            default: c = '{OP_SUB, R_PAA, R_T3, R_PAA};
        endcase
        return c;
    endfunction

    assign in_ready  = (state_reg == S_IDLE);
    assign load_in   = in_ready && in_valid;
    assign cmd_valid = (state_reg == S_RUN) || (state_reg == S_SEED);
    assign cmd       = (state_reg == S_SEED) ? kabf_cmd_t'{OP_LOAD, R_MEAS, R_MEAS, R_ANG}
                                             : prog(pc_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            pc_reg    <= '0;
            done      <= 1'b0;
        end
        else
        begin
            done <= 1'b0;
            case (state_reg)
                S_IDLE:
                    if (in_valid)
                    begin
                        pc_reg    <= '0;
                        state_reg <= (in_cmd == CMD_SEED) ? S_SEED : S_RUN;
                    end
                S_SEED:
                    if (!out_hold)
                    begin
                        done      <= 1'b1;
                        state_reg <= S_IDLE;
                    end
                S_RUN:
                    state_reg <= S_WAIT;
                S_WAIT:
                    if (!stat.busy)
                    begin
                        if (pc_reg == PC_W'(PROG_LEN))
                        begin
                            if (!out_hold)
                            begin
                                done      <= 1'b1;
                                state_reg <= S_IDLE;
                            end
                        end
                        else
                        begin
                            pc_reg    <= pc_reg + 1'b1;
                            state_reg <= S_RUN;
                        end
                    end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

endmodule

// File: design/kalman_angle_bias_filter.sv
// Top level of the two-state angle and gyro-bias Kalman filter.
`timescale 1ns / 1ps
// Usage: a sample transaction enters on in_valid/in_stall with in_data, and
// the noise registers are written over cfg_we/cfg_index/cfg_data while no
// sample is in flight. A seed command loads the measured angle as the angle
// estimate; a step command runs predict and update. Each input gives exactly
// one result transaction on out_valid/out_stall carrying the angle and bias
// estimates after the command.
// The block works on one sample at a time. A seed shows its result at the
// same edge at which the next sample can be taken. A step runs 29 sequencer
// operations: 17 adds and subtracts, 10 multiplies and 2 serial divisions;
// the divisions take most of its time. A finished result is held in an
// output register. The next sample is taken while that result waits, and
// the sequencer holds at its last operation until the held result is taken,
// so a stalled receiver stalls the input. Reset clears estimates and
// covariance to zero and loads the default noise registers.
module kalman_angle_bias_filter
    import kabf_pkg::*;
#(
    parameter int WORD_BITS = WORD_BITS_DEF,
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_stall,
    input  kabf_in_t                in_data,
    output logic                    out_valid,
    input  logic                    out_stall,
    output kabf_out_t               out_data,
    input  logic                    cfg_we,
    input  logic [CFG_IDX_BITS-1:0] cfg_index,
    input  logic [CFG_BITS-1:0]     cfg_data
);

    logic [CFG_BITS-1:0] qa_reg, qb_reg, rm_reg;
    logic       ready, load_in, cmd_valid, done;
    kabf_cmd_t  cmd;
    kabf_stat_t stat;
    kabf_out_t  result;
    logic       out_hold;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            qa_reg <= ANGLE_NOISE_RST;
            qb_reg <= BIAS_NOISE_RST;
            rm_reg <= MEASURE_NOISE_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_ANGLE_NOISE:   qa_reg <= cfg_data;
                REG_BIAS_NOISE:    qb_reg <= cfg_data;
                REG_MEASURE_NOISE: rm_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // A new sample is refused only while the controller is busy.
    assign in_stall = !ready;

    // The held result stays in the output register at the next edge.
    assign out_hold = out_valid && out_stall;

    kabf_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_cmd    (in_data.command),
        .in_ready  (ready),
        .load_in   (load_in),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .stat      (stat),
        .out_hold  (out_hold),
        .done      (done)
    );

    kabf_datapath #(
        .WORD_BITS (WORD_BITS),
        .FRAC_BITS (FRAC_BITS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .stat      (stat),
        .load_in   (load_in),
        .in_item   (in_data),
        .qa_cfg    (qa_reg),
        .qb_cfg    (qb_reg),
        .rm_cfg    (rm_reg),
        .result    (result)
    );

    // Output register: captured when a command finishes, held until taken.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid <= 1'b0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                out_valid <= 1'b0;
            end
            if (done)
            begin
                out_valid <= 1'b1;
                out_data  <= result;
            end
        end
    end

endmodule

// File: sim/kalman_angle_bias_filter_tb.sv
// Self-checking testbench of the angle and gyro-bias Kalman filter.
`timescale 1ns / 1ps
module kalman_angle_bias_filter_tb
    import kabf_pkg::*;
;

    localparam int  CYCLE_LIMIT = 3000000;
    localparam int  DRAIN_CYCLES = 400;
    localparam longint WMAX = 64'sd2147483647;
    localparam longint WMIN = -64'sd2147483648;

    logic                    clk;
    logic                    rst_n;
    logic                    in_valid;
    logic                    in_stall;
    kabf_in_t                in_data;
    logic                    out_valid;
    logic                    out_stall;
    kabf_out_t               out_data;
    logic                    cfg_we;
    logic [CFG_IDX_BITS-1:0] cfg_index;
    logic [CFG_BITS-1:0]     cfg_data;

    kalman_angle_bias_filter u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Filter state as the testbench tracks it, one word per state variable.
    longint   est_angle, est_bias, p_aa, p_ab, p_ba, p_bb;
    longint   q_angle, q_bias, r_meas;
    kabf_out_t pending_estimates[$];

    int       error_count;
    int       cycle_count;
    int       send_idle_pct;
    int       recv_stall_pct;
    int       hold_off_cycles;

    initial clk = 1'b0;
    always #2 clk = ~clk;

    // Saturating arithmetic in the block's Q8.24 word.
    function automatic longint sat_word(input longint v);
        if (v > WMAX) return WMAX;
        if (v < WMIN) return WMIN;
        return v;
    endfunction

    function automatic longint sat_signed_mag(input logic [127:0] m, input logic neg);
        logic [127:0] lim;
        lim = neg ? 128'h8000_0000 : 128'h7FFF_FFFF;
        if (m > lim) m = lim;
        return neg ? -longint'(m[63:0]) : longint'(m[63:0]);
    endfunction

    function automatic logic [127:0] abs_wide(input longint v);
        logic [63:0] m;
        m = (v < 0) ? 64'(-v) : 64'(v);
        return {64'd0, m};
    endfunction

    // Product shifted down by the fraction bits, rounded half away from zero.
    function automatic longint fx_mul(input longint a, input longint b);
        logic [127:0] p;
        p = abs_wide(a) * abs_wide(b) + (128'd1 << 23);
        return sat_signed_mag(p >> 24, (a < 0) != (b < 0));
    endfunction

    // Quotient scaled up by the fraction bits; a zero divisor yields zero.
    function automatic longint fx_div(input longint n, input longint d);
        logic [127:0] num, den, q, r;
        if (d == 0) return 0;
        num = abs_wide(n) << 24;
        den = abs_wide(d);
        q = num / den;
        r = num % den;
        if (r >= den - r) q = q + 1;
        return sat_signed_mag(q, (n < 0) != (d < 0));
    endfunction

    // Advances the tracked filter by one sample and returns the new estimates.
    function automatic kabf_out_t filter_update(input kabf_in_t s);
        longint meas, gyro, dt, t, d, y, sv, k0, k1, p00, p01;
        kabf_out_t r;
        meas = longint'(s.measured_angle);
        gyro = longint'(s.gyro_rate);
        dt   = longint'({40'd0, s.time_step});
        if (s.command == CMD_SEED)
        begin
            est_angle = meas;
        end
        else
        begin
            est_angle = sat_word(est_angle + fx_mul(dt, sat_word(gyro - est_bias)));
            t = sat_word(sat_word(sat_word(fx_mul(dt, p_bb) - p_ab) - p_ba) + q_angle);
            p_aa = sat_word(p_aa + fx_mul(dt, t));
            d = fx_mul(dt, p_bb);
            p_ab = sat_word(p_ab - d);
            p_ba = sat_word(p_ba - d);
            p_bb = sat_word(p_bb + fx_mul(q_bias, dt));
            y  = sat_word(meas - est_angle);
            sv = sat_word(p_aa + r_meas);
            k0 = fx_div(p_aa, sv);
            k1 = fx_div(p_ba, sv);
            est_angle = sat_word(est_angle + fx_mul(k0, y));
            est_bias  = sat_word(est_bias + fx_mul(k1, y));
            p00 = p_aa;
            p01 = p_ab;
            p_aa = sat_word(p_aa - fx_mul(k0, p00));
            p_ab = sat_word(p_ab - fx_mul(k0, p01));
            p_ba = sat_word(p_ba - fx_mul(k1, p00));
            p_bb = sat_word(p_bb - fx_mul(k1, p01));
        end
        r.angle_estimate = est_angle[31:0];
        r.bias_estimate  = est_bias[31:0];
        return r;
    endfunction

    // Offers one sample and returns once the block has taken the transaction.
    // Valid stays high afterwards until the next sample or an idle cycle.
    task automatic send_sample(input kabf_in_t s);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= s;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        pending_estimates.push_back(filter_update(s));
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (pending_estimates.size() != 0) @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_noise(input logic [CFG_IDX_BITS-1:0] idx, input logic [23:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            REG_ANGLE_NOISE:   q_angle = longint'({40'd0, val});
            REG_BIAS_NOISE:    q_bias  = longint'({40'd0, val});
            REG_MEASURE_NOISE: r_meas  = longint'({40'd0, val});
            default: ;
        endcase
    endtask

    task automatic set_noise(input logic [23:0] qa, input logic [23:0] qb,
                             input logic [23:0] rm);
        wait_drained();
        write_noise(REG_ANGLE_NOISE, qa);
        write_noise(REG_BIAS_NOISE, qb);
        write_noise(REG_MEASURE_NOISE, rm);
    endtask

    function automatic kabf_in_t make_sample(input logic cmd, input int ang,
                                             input int rate, input logic [23:0] dt);
        kabf_in_t s;
        s.command        = cmd;
        s.measured_angle = ang;
        s.gyro_rate      = rate;
        s.time_step      = dt;
        return s;
    endfunction

    // Mostly realistic samples: small angles and rates, 1 to 20 ms steps.
    // One in eight is full-range noise so every payload bit toggles.
    function automatic kabf_in_t random_sample();
        kabf_in_t s;
        if ($urandom_range(7) == 0)
        begin
            s = make_sample(1'($urandom_range(1)), $urandom, $urandom, 24'($urandom));
        end
        else
        begin
            s = make_sample($urandom_range(15) == 0 ? CMD_SEED : CMD_STEP,
                            $signed($urandom_range(52000000)) - 26000000,
                            $signed($urandom_range(8000000)) - 4000000,
                            24'($urandom_range(335544, 16777)));
        end
        return s;
    endfunction

    task automatic test_directed();
        send_sample(make_sample(CMD_STEP, 0, 0, 24'd0));
        send_sample(make_sample(CMD_SEED, 32'sh7FFF_FFFF, 0, 24'd0));
        send_sample(make_sample(CMD_STEP, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 24'hFF_FFFF));
        send_sample(make_sample(CMD_SEED, 32'sh8000_0000, 32'sh8000_0000, 24'hFF_FFFF));
        send_sample(make_sample(CMD_STEP, 32'sh8000_0000, 32'sh8000_0000, 24'hFF_FFFF));
        send_sample(make_sample(CMD_STEP, 32'sh8000_0000, 32'sh7FFF_FFFF, 24'd1));
        send_sample(make_sample(CMD_SEED, 0, 32'sh7FFF_FFFF, 24'd16777));
        for (int i = 0; i < 8; i++)
            send_sample(make_sample(CMD_STEP, 16777216, 1677721, 24'd167772));
        send_sample(make_sample(CMD_STEP, -16777216, -1677721, 24'hFF_FFFF));
        send_sample(make_sample(CMD_STEP, 32'sh7FFF_FFFF, 32'sh8000_0000, 24'h80_0000));
        send_sample(make_sample(CMD_SEED, -1, -1, 24'd1));
        wait_drained();
    endtask

    task automatic test_random(input int n, input int idle_pct, input int stall_pct);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        for (int i = 0; i < n; i++) send_sample(random_sample());
        wait_drained();
    endtask

    // The receiver holds off while the sender keeps pushing, so the block
    // fills and stalls its input. Then the sender pauses until drained.
    task automatic test_backpressure();
        send_idle_pct   = 0;
        recv_stall_pct  = 0;
        hold_off_cycles = 2000;
        for (int i = 0; i < 12; i++) send_sample(random_sample());
        wait_drained();
        for (int i = 0; i < 6; i++) send_sample(random_sample());
        wait_drained();
    endtask

    task automatic test_noise_settings();
        set_noise(24'd0, 24'd0, 24'd1);
        test_random(40, 11, 11);
        set_noise(24'hFF_FFFF, 24'hFF_FFFF, 24'hFF_FFFF);
        test_random(40, 11, 11);
        set_noise(24'hFF_FFFF, 24'd0, 24'd1);
        test_random(30, 0, 0);
        set_noise(24'($urandom), 24'($urandom), 24'($urandom_range(24'hFF_FFFF, 1)));
        test_random(30, 0, 0);
        set_noise(ANGLE_NOISE_RST, BIAS_NOISE_RST, MEASURE_NOISE_RST);
    endtask

    // Receiver stall generator with a counted long hold-off on request.
    always @(posedge clk)
    begin
        if (hold_off_cycles > 0)
        begin
            hold_off_cycles <= hold_off_cycles - 1;
            out_stall <= 1'b1;
        end
        else
        begin
            out_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    // Every result transaction is checked against the oldest expectation.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_estimates.size() == 0)
            begin
                $error("unexpected result angle=%0d bias=%0d",
                       out_data.angle_estimate, out_data.bias_estimate);
                error_count++;
            end
            else
            begin
                kabf_out_t exp_r;
                exp_r = pending_estimates.pop_front();
                if (out_data.angle_estimate !== exp_r.angle_estimate)
                begin
                    $error("angle_estimate expected %0d actual %0d",
                           exp_r.angle_estimate, out_data.angle_estimate);
                    error_count++;
                end
                if (out_data.bias_estimate !== exp_r.bias_estimate)
                begin
                    $error("bias_estimate expected %0d actual %0d",
                           exp_r.bias_estimate, out_data.bias_estimate);
                    error_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("kalman_angle_bias_filter_tb NOT OK");
            $finish;
        end
    end

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        out_stall = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        error_count = 0;
        cycle_count = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_off_cycles = 0;
        est_angle = 0; est_bias = 0;
        p_aa = 0; p_ab = 0; p_ba = 0; p_bb = 0;
        q_angle = longint'({40'd0, ANGLE_NOISE_RST});
        q_bias  = longint'({40'd0, BIAS_NOISE_RST});
        r_meas  = longint'({40'd0, MEASURE_NOISE_RST});
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_random(110, 0, 0);
        test_random(110, 53, 0);
        test_random(110, 0, 53);
        test_random(110, 11, 11);
        test_backpressure();
        test_noise_settings();

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0 && pending_estimates.size() == 0)
            $display("kalman_angle_bias_filter_tb OK");
        else
            $display("kalman_angle_bias_filter_tb NOT OK");
        $finish;
    end

endmodule
